// ===== rtl/lru_writeback_slot_cache_macros.svh =====
// Assertion macros for the slot cache checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef LRU_WRITEBACK_SLOT_CACHE_MACROS_SVH
`define LRU_WRITEBACK_SLOT_CACHE_MACROS_SVH

// checked only while out of reset
`define LWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define LWSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/lwsc_pkg.sv =====
// Shared types and constants of the slot cache controller.
// No dependencies.
package lwsc_pkg;

  localparam int KIND_W      = 3;
  localparam int CLUSTER_W   = 32;
  localparam int STAMP_W     = 32;
  localparam int SLOT_OUT_W  = 3;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 4;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP     = 3'd0,
    KIND_MARK_DIRTY = 3'd1,
    KIND_FLUSH_SLOT = 3'd2,
    KIND_FLUSH_ALL  = 3'd3,
    KIND_INVALIDATE = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RD_ONE,
    ST_FLUSH_ONE,
    ST_FA_SCAN,
    ST_FA_EMIT,
    ST_FA_DONE,
    ST_SIMPLE
  } state_e;

  typedef struct packed {
    logic                  status;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic                  fill;
    logic                  wb_valid;
    logic [SLOT_OUT_W-1:0] wb_slot;
    logic [CLUSTER_W-1:0]  wb_cluster;
    logic                  last;
  } res_t;

endpackage

// ===== rtl/lwsc_scan_unit.sv =====
// Shared compare unit: one slot per cycle, tag match and oldest-stamp search.
// Depends on lwsc_pkg.
module lwsc_scan_unit #(
  parameter int SW = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           valid_i,
  input  logic [SW-1:0]                  idx_i,
  input  logic [lwsc_pkg::CLUSTER_W-1:0] tag_i,
  input  logic [lwsc_pkg::STAMP_W-1:0]   stamp_i,
  input  logic [lwsc_pkg::CLUSTER_W-1:0] key_i,
  output logic                           hit_o,
  output logic [SW-1:0]                  hit_idx_o,
  output logic                           found_o,
  output logic [SW-1:0]                  min_idx_o,
  output logic [lwsc_pkg::CLUSTER_W-1:0] min_tag_o
);
  import lwsc_pkg::*;

  logic               hit_q, found_q;
  logic [SW-1:0]      hit_idx_q, min_idx_q;
  logic [CLUSTER_W-1:0] min_tag_q;
  logic [STAMP_W-1:0] oldest_q;
  logic               eq, lt;

  assign eq = (tag_i == key_i);
  assign lt = (stamp_i < oldest_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      oldest_q <= STAMP_MAX;
    end else if (clear_i) begin
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      oldest_q <= STAMP_MAX;
    end else if (valid_i) begin
      if (eq) hit_q <= 1'b1;
      if (lt) begin
        found_q  <= 1'b1;
        oldest_q <= stamp_i;
      end
    end
  end

  // first match wins; strict compare keeps the lowest slot among equal stamps
  always_ff @(posedge clk_i) begin
    if (valid_i && !clear_i) begin
      if (eq && !hit_q) hit_idx_q <= idx_i;
      if (lt) begin
        min_idx_q <= idx_i;
        min_tag_q <= tag_i;
      end
    end
  end

  assign hit_o     = hit_q;
  assign hit_idx_o = hit_idx_q;
  assign found_o   = found_q;
  assign min_idx_o = min_idx_q;
  assign min_tag_o = min_tag_q;

endmodule

// ===== rtl/lru_writeback_slot_cache.sv =====
// Lookup: accept, one tag/stamp read per valid slot, drain of the read and compare
// registers, then a decide step. Mark dirty and unknown kinds: accept, then the result.
// Flush one slot: accept, read of the slot, result. Flush all and invalidate: a scan of
// the valid slots with a read and a result per dirty slot, then a closing step;
// result stalls add to each. Single tag/stamp read port, shared compare unit, one
// request at a time. Reset (rst_ni, async, low) empties the cache, dirty bits, counter.
module lru_writeback_slot_cache #(
  parameter int SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lwsc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // cluster_index, slot
  input  logic [lwsc_pkg::KIND_W-1:0]     s_axis_tuser_i,  // kind
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lwsc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // slot_out, writeback_slot,
                                                           // writeback_cluster
  output logic [lwsc_pkg::OUT_USER_W-1:0] m_axis_tuser_o,  // status, hit, fill_request,
                                                           // writeback_valid
  output logic                            m_axis_tlast_o
);
  import lwsc_pkg::*;

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > SLOT_OUT_W) ? CW : SLOT_OUT_W;

  state_e state_q, state_d;
  kind_e  kind_q, kind_in;
  logic [CLUSTER_W-1:0]  key_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [CW-1:0]         idx_q, used_q;
  logic [CNT_W-1:0]      n_q;
  logic [STAMP_W-1:0]    ctr_q, stamp_next;
  logic [SLOTS-1:0]      dirty_q, dirty_d, more;
  logic                  rd_vld_q;
  logic [SW-1:0]         rd_idx_q;
  logic [CLUSTER_W-1:0]  tag_rd_q;
  logic [STAMP_W-1:0]    stamp_rd_q;
  logic                  m_valid_q;
  res_t                  m_res_q, res;

  logic [CLUSTER_W-1:0]  tag_mem   [SLOTS];
  logic [STAMP_W-1:0]    stamp_mem [SLOTS];

  logic accept, out_free, slot_ok, fa_last, fa_end, fa_fin;
  logic rd_en, scan_clear, idx_inc, emit, tag_we, stamp_we;
  logic dirty_set, dirty_clr, inval, used_inc, ctr_inc, n_inc;
  logic [SW-1:0] rd_addr, wr_addr, dirty_idx;

  logic               hit, found;
  logic [SW-1:0]      hit_idx, min_idx;
  logic [CLUSTER_W-1:0] min_tag;

  lwsc_scan_unit #(.SW(SW)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (scan_clear),
    .valid_i   (rd_vld_q),
    .idx_i     (rd_idx_q),
    .tag_i     (tag_rd_q),
    .stamp_i   (stamp_rd_q),
    .key_i     (key_q),
    .hit_o     (hit),
    .hit_idx_o (hit_idx),
    .found_o   (found),
    .min_idx_o (min_idx),
    .min_tag_o (min_tag)
  );

  assign kind_in         = kind_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign stamp_next      = ctr_q + 32'd1;
  assign slot_ok         = (CMPW'(slot_q) < CMPW'(used_q));

  // dirty valid slots above the current flush position
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      more[j] = dirty_q[j] && (CW'(j) > idx_q) && (CW'(j) < used_q);
    end
  end

  assign fa_last = (n_q == CNT_W'(MAX_RESULTS - 1)) || !(|more);
  assign fa_end  = (idx_q >= used_q) || (n_q == CNT_W'(MAX_RESULTS));
  assign fa_fin  = (n_q != '0) || out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_in)
            KIND_LOOKUP:     state_d = ST_SCAN;
            KIND_FLUSH_SLOT: state_d = ST_RD_ONE;
            KIND_FLUSH_ALL,
            KIND_INVALIDATE: state_d = ST_FA_SCAN;
            default:         state_d = ST_SIMPLE;
          endcase
        end
      end
      ST_SCAN:      if (idx_q == used_q && !rd_vld_q) state_d = ST_DECIDE;
      ST_DECIDE:    if (out_free) state_d = ST_IDLE;
      ST_RD_ONE:    state_d = ST_FLUSH_ONE;
      ST_FLUSH_ONE: if (out_free) state_d = ST_IDLE;
      ST_FA_SCAN: begin
        priority if (fa_end)                 state_d = ST_FA_DONE;
        else if (dirty_q[idx_q[SW-1:0]])     state_d = ST_FA_EMIT;
        else                                 state_d = ST_FA_SCAN;
      end
      ST_FA_EMIT:   if (out_free) state_d = fa_last ? ST_FA_DONE : ST_FA_SCAN;
      ST_FA_DONE:   if (fa_fin) state_d = ST_IDLE;
      ST_SIMPLE:    if (out_free) state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = idx_q[SW-1:0];
    scan_clear = 1'b0;
    idx_inc    = 1'b0;
    emit       = 1'b0;
    res        = '0;
    res.last   = 1'b1;
    tag_we     = 1'b0;
    stamp_we   = 1'b0;
    wr_addr    = used_q[SW-1:0];
    dirty_set  = 1'b0;
    dirty_clr  = 1'b0;
    dirty_idx  = idx_q[SW-1:0];
    inval      = 1'b0;
    used_inc   = 1'b0;
    ctr_inc    = 1'b0;
    n_inc      = 1'b0;
    unique case (state_q)
      ST_IDLE: scan_clear = 1'b1;
      ST_SCAN: begin
        if (idx_q < used_q) begin
          rd_en   = 1'b1;
          idx_inc = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          emit = 1'b1;
          priority if (hit) begin
            ctr_inc      = 1'b1;
            stamp_we     = 1'b1;
            wr_addr      = hit_idx;
            res.hit      = 1'b1;
            res.slot_out = SLOT_OUT_W'(hit_idx);
          end else if (used_q < CW'(SLOTS)) begin
            tag_we       = 1'b1;
            stamp_we     = 1'b1;
            wr_addr      = used_q[SW-1:0];
            dirty_clr    = 1'b1;
            dirty_idx    = used_q[SW-1:0];
            used_inc     = 1'b1;
            ctr_inc      = 1'b1;
            res.fill     = 1'b1;
            res.slot_out = SLOT_OUT_W'(used_q[SW-1:0]);
          end else if (!found) begin
            res.status = 1'b1;
          end else begin
            tag_we       = 1'b1;
            stamp_we     = 1'b1;
            wr_addr      = min_idx;
            dirty_clr    = 1'b1;
            dirty_idx    = min_idx;
            ctr_inc      = 1'b1;
            res.fill     = 1'b1;
            res.slot_out = SLOT_OUT_W'(min_idx);
            if (dirty_q[min_idx]) begin
              res.wb_valid   = 1'b1;
              res.wb_slot    = SLOT_OUT_W'(min_idx);
              res.wb_cluster = min_tag;
            end
          end
        end
      end
      ST_RD_ONE: begin
        rd_en   = 1'b1;
        rd_addr = SW'(slot_q);
      end
      ST_FLUSH_ONE: begin
        if (out_free) begin
          emit         = 1'b1;
          res.slot_out = slot_q;
          if (slot_ok && dirty_q[SW'(slot_q)]) begin
            res.wb_valid   = 1'b1;
            res.wb_slot    = slot_q;
            res.wb_cluster = tag_rd_q;
            dirty_clr      = 1'b1;
            dirty_idx      = SW'(slot_q);
          end
        end
      end
      ST_FA_SCAN: begin
        if (!fa_end) begin
          if (dirty_q[idx_q[SW-1:0]]) rd_en = 1'b1;
          else                        idx_inc = 1'b1;
        end
      end
      ST_FA_EMIT: begin
        if (out_free) begin
          emit           = 1'b1;
          res.wb_valid   = 1'b1;
          res.wb_slot    = SLOT_OUT_W'(idx_q[SW-1:0]);
          res.wb_cluster = tag_rd_q;
          res.last       = fa_last;
          dirty_clr      = 1'b1;
          n_inc          = 1'b1;
          idx_inc        = 1'b1;
        end
      end
      ST_FA_DONE: begin
        // nothing flushed: a single empty result closes the request
        if (n_q == '0 && out_free) emit = 1'b1;
        if (fa_fin && kind_q == KIND_INVALIDATE) inval = 1'b1;
      end
      ST_SIMPLE: begin
        if (out_free) begin
          emit = 1'b1;
          if (kind_q == KIND_MARK_DIRTY) begin
            res.slot_out = slot_q;
            dirty_set    = slot_ok;
            dirty_idx    = SW'(slot_q);
          end
        end
      end
    endcase
  end

  always_comb begin
    dirty_d = dirty_q;
    if (inval) begin
      dirty_d = '0;
    end else begin
      if (dirty_set) dirty_d[dirty_idx] = 1'b1;
      if (dirty_clr) dirty_d[dirty_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      n_q       <= '0;
      used_q    <= '0;
      ctr_q     <= '0;
      dirty_q   <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dirty_q  <= dirty_d;
      rd_vld_q <= rd_en;
      if (accept)       idx_q <= '0;
      else if (idx_inc) idx_q <= idx_q + 1'b1;
      if (accept)       n_q <= '0;
      else if (n_inc)   n_q <= n_q + 1'b1;
      if (inval)         used_q <= '0;
      else if (used_inc) used_q <= used_q + 1'b1;
      if (ctr_inc) ctr_q <= stamp_next;
      if (emit)                 m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_in;
      key_q  <= s_axis_tdata_i[CLUSTER_W-1:0];
      slot_q <= s_axis_tdata_i[CLUSTER_W +: SLOT_OUT_W];
    end
    if (rd_en) rd_idx_q <= rd_addr;
    if (emit)  m_res_q  <= res;
  end

  // tag and stamp stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (tag_we)   tag_mem[wr_addr]   <= key_q;
    if (stamp_we) stamp_mem[wr_addr] <= stamp_next;
    if (rd_en) begin
      tag_rd_q   <= tag_mem[rd_addr];
      stamp_rd_q <= stamp_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({m_res_q.wb_cluster, m_res_q.wb_slot, m_res_q.slot_out});
  assign m_axis_tuser_o  = {m_res_q.wb_valid, m_res_q.fill, m_res_q.hit, m_res_q.status};
  assign m_axis_tlast_o  = m_res_q.last;

endmodule

// ===== rtl/lwsc_checker.sv =====
// Port-level checks of the slot cache, bound to the top level.
// Depends on lwsc_pkg and lru_writeback_slot_cache_macros.svh.
`include "lru_writeback_slot_cache_macros.svh"

module lwsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [lwsc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [lwsc_pkg::OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);
  import lwsc_pkg::*;

  // an edge with reset low leaves no result valid at the next edge
  `LWSC_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid_o, "result valid in reset")

  // one request at a time: ready drops right after a request is taken
  `LWSC_ASSERT(a_busy_after_req, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "ready after request")

  `LWSC_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // a hit neither fills nor writes back, and is a single result
  `LWSC_ASSERT(a_hit_clean, m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[2] && !m_axis_tuser_o[3] && m_axis_tlast_o, "hit with fill or writeback")

  `LWSC_ASSERT(a_no_victim, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tuser_o[3:1] == 3'b000 && m_axis_tdata_o == '0 && m_axis_tlast_o, "no-victim result not empty")

endmodule

bind lru_writeback_slot_cache lwsc_checker u_lwsc_checker (.*);

// ===== dv/lru_writeback_slot_cache_test.sv =====
// Self-checking testbench for the slot cache tag and replacement controller.
// Queue-fed stream driver with its own LRU/dirty predictor, stream monitor.
// Depends on lwsc_pkg and lru_writeback_slot_cache.
module lru_writeback_slot_cache_test;
  import lwsc_pkg::*;

  localparam int SLOTS        = 8;
  localparam int KIND_CODES   = 1 << KIND_W;
  localparam int POOL_SIZE    = 12;
  localparam int RANDOM_ITEMS = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [CLUSTER_W-1:0]  cluster;
    logic [SLOT_OUT_W-1:0] slot;
    bit                    drain;  // hold this request until all results are back
  } request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  request_t pending_reqs[$];
  request_t cur_req;
  res_t     expected_results[$];

  // predictor state
  logic [CLUSTER_W-1:0] slot_tag   [SLOTS];
  logic [STAMP_W-1:0]   slot_stamp [SLOTS];
  bit                   slot_dirty [SLOTS];
  int                   used_slots;
  logic [STAMP_W-1:0]   stamp_ctr;

  int  n_sent, n_results, n_hits, n_writebacks, n_errors;
  bit  timed_out;
  logic [CLUSTER_W-1:0] cluster_pool [POOL_SIZE];

  always #5 clk_i = ~clk_i;

  lru_writeback_slot_cache #(.SLOTS(SLOTS)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("mismatch %0d at result %0d: %s", n_errors, n_results, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Writebacks of every dirty valid slot, lowest first, at most MAX_RESULTS; one empty result if none.
  task automatic flush_dirty_slots();
    res_t batch [MAX_RESULTS];
    int   n;
    n = 0;
    for (int i = 0; i < used_slots && n < MAX_RESULTS; i++) begin
      if (slot_dirty[i]) begin
        batch[n]            = '0;
        batch[n].wb_valid   = 1'b1;
        batch[n].wb_slot    = i[SLOT_OUT_W-1:0];
        batch[n].wb_cluster = slot_tag[i];
        slot_dirty[i]       = 1'b0;
        n++;
      end
    end
    if (n == 0) begin
      batch[0] = '0;
      n = 1;
    end
    batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(batch[i]);
  endtask

  task automatic predict_request(input request_t rq);
    res_t                 r;
    bit                   hit;
    bit                   have_victim;
    int                   victim;
    logic [STAMP_W-1:0]   oldest;
    r      = '0;
    r.last = 1'b1;
    case (rq.kind)
      KIND_LOOKUP: begin
        hit = 1'b0;
        for (int i = 0; i < used_slots; i++) begin
          if (!hit && slot_tag[i] == rq.cluster) begin
            hit           = 1'b1;
            stamp_ctr     = stamp_ctr + 1;
            slot_stamp[i] = stamp_ctr;
            r.hit         = 1'b1;
            r.slot_out    = i[SLOT_OUT_W-1:0];
          end
        end
        if (!hit) begin
          have_victim = 1'b0;
          victim      = 0;
          if (used_slots < SLOTS) begin
            victim      = used_slots;
            used_slots  = used_slots + 1;
            have_victim = 1'b1;
          end else begin
            // strictly older than all-ones; first minimum wins
            oldest = STAMP_MAX;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_stamp[i] < oldest) begin
                oldest      = slot_stamp[i];
                victim      = i;
                have_victim = 1'b1;
              end
            end
            if (have_victim && slot_dirty[victim]) begin
              r.wb_valid   = 1'b1;
              r.wb_slot    = victim[SLOT_OUT_W-1:0];
              r.wb_cluster = slot_tag[victim];
            end
          end
          if (!have_victim) begin
            r.status = 1'b1;
          end else begin
            slot_tag[victim]   = rq.cluster;
            slot_dirty[victim] = 1'b0;
            stamp_ctr          = stamp_ctr + 1;
            slot_stamp[victim] = stamp_ctr;
            r.slot_out         = victim[SLOT_OUT_W-1:0];
            r.fill             = 1'b1;
          end
        end
        expected_results.push_back(r);
      end
      KIND_MARK_DIRTY: begin
        if (rq.slot < used_slots) slot_dirty[rq.slot] = 1'b1;
        r.slot_out = rq.slot;
        expected_results.push_back(r);
      end
      KIND_FLUSH_SLOT: begin
        r.slot_out = rq.slot;
        if (rq.slot < used_slots && slot_dirty[rq.slot]) begin
          slot_dirty[rq.slot] = 1'b0;
          r.wb_valid          = 1'b1;
          r.wb_slot           = rq.slot;
          r.wb_cluster        = slot_tag[rq.slot];
        end
        expected_results.push_back(r);
      end
      KIND_FLUSH_ALL: flush_dirty_slots();
      KIND_INVALIDATE: begin
        flush_dirty_slots();
        used_slots = 0;
        for (int i = 0; i < SLOTS; i++) slot_dirty[i] = 1'b0;
      end
      default: expected_results.push_back(r);
    endcase
  endtask

  task automatic add_req(input int kind, input logic [CLUSTER_W-1:0] cluster,
                         input int slot, input bit drain);
    request_t rq;
    rq.kind    = kind[KIND_W-1:0];
    rq.cluster = cluster;
    rq.slot    = slot[SLOT_OUT_W-1:0];
    rq.drain   = drain;
    pending_reqs.push_back(rq);
  endtask

  function automatic int any_slot();
    return $urandom_range(0, SLOTS - 1);
  endfunction

  function automatic int bad_kind();
    return $urandom_range(int'(KIND_INVALIDATE) + 1, KIND_CODES - 1);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : feed
    logic [IN_DATA_W-1:0] din;
    bit                   fire;
    bit                   nxt_valid;
    int                   gap_left;
    int                   calm_left;
    if (!rst_ni) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      s_tuser   <= '0;
      gap_left  = 0;
      calm_left = 0;
    end else begin
      fire      = s_tvalid && s_tready;
      nxt_valid = s_tvalid && !fire;
      if (fire) begin
        predict_request(cur_req);
        n_sent++;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = idle_len();
          if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 30);
        end
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_results.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          din     = '0;
          din[CLUSTER_W-1:0]                      = cur_req.cluster;
          din[CLUSTER_W+SLOT_OUT_W-1:CLUSTER_W]   = cur_req.slot;
          s_tdata   <= din;
          s_tuser   <= cur_req.kind;
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t got;
    res_t want;
    int   stall_left;
    int   calm_left;
    int   nxt;
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status     = m_tuser[0];
        got.hit        = m_tuser[1];
        got.fill       = m_tuser[2];
        got.wb_valid   = m_tuser[3];
        got.slot_out   = m_tdata[SLOT_OUT_W-1:0];
        got.wb_slot    = m_tdata[2*SLOT_OUT_W-1:SLOT_OUT_W];
        got.wb_cluster = m_tdata[2*SLOT_OUT_W+CLUSTER_W-1:2*SLOT_OUT_W];
        got.last       = m_tlast;
        n_results++;
        if (got.hit === 1'b1) n_hits++;
        if (got.wb_valid === 1'b1) n_writebacks++;
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("hit", 32'(got.hit), 32'(want.hit));
          check_field("slot_out", 32'(got.slot_out), 32'(want.slot_out));
          check_field("fill_request", 32'(got.fill), 32'(want.fill));
          check_field("writeback_valid", 32'(got.wb_valid), 32'(want.wb_valid));
          check_field("writeback_slot", 32'(got.wb_slot), 32'(want.wb_slot));
          check_field("writeback_cluster", got.wb_cluster, want.wb_cluster);
          check_field("last", 32'(got.last), 32'(want.last));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        nxt        = idle_len();
        stall_left = (nxt > 0) ? nxt - 1 : 0;
        m_tready   <= (nxt == 0);
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin : dog
    int quiet;
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    int base;
    int pick;
    int n_total;
    used_slots   = 0;
    stamp_ctr    = '0;
    n_sent       = 0;
    n_results    = 0;
    n_hits       = 0;
    n_writebacks = 0;
    n_errors     = 0;
    timed_out    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_tag[i]   = '0;
      slot_stamp[i] = '0;
      slot_dirty[i] = 1'b0;
    end

    // directed: empty cache, invalid slots, unknown kinds, hit/miss, eviction
    add_req(KIND_LOOKUP, 32'h0000_0000, 0, 0);
    add_req(KIND_MARK_DIRTY, $urandom(), SLOTS - 1, 0);   // slot not valid
    add_req(KIND_FLUSH_SLOT, $urandom(), 5, 0);           // slot not valid
    add_req(KIND_FLUSH_ALL, $urandom(), any_slot(), 0);   // nothing dirty
    add_req(KIND_INVALIDATE, $urandom(), any_slot(), 0);
    add_req(KIND_LOOKUP, 32'h0000_0000, 0, 0);
    for (int k = int'(KIND_INVALIDATE) + 1; k < KIND_CODES; k++)
      add_req(k, $urandom(), any_slot(), 0);
    add_req(KIND_LOOKUP, 32'hFFFF_FFFF, SLOTS - 1, 0);
    add_req(KIND_LOOKUP, 32'h0000_0000, 0, 0);            // hit
    add_req(KIND_MARK_DIRTY, 32'hFFFF_FFFF, 0, 0);
    add_req(KIND_FLUSH_SLOT, 32'h0000_0000, 0, 0);        // writeback
    add_req(KIND_FLUSH_SLOT, 32'hFFFF_FFFF, 0, 0);        // now clean
    for (int i = 1; i <= SLOTS - 2; i++) add_req(KIND_LOOKUP, i, 0, 0);
    add_req(KIND_MARK_DIRTY, 0, 1, 0);
    add_req(KIND_MARK_DIRTY, 0, 3, 0);
    add_req(KIND_LOOKUP, 32'h8000_0000, 0, 0);            // evicts dirty LRU slot
    add_req(KIND_FLUSH_ALL, 0, 0, 0);
    add_req(KIND_INVALIDATE, 0, 0, 1);

    cluster_pool[0] = '0;
    cluster_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) cluster_pool[i] = $urandom();

    base = pending_reqs.size();
    while (pending_reqs.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        add_req(KIND_LOOKUP,
                ($urandom_range(0, 9) == 0) ? $urandom()
                                            : cluster_pool[$urandom_range(0, POOL_SIZE - 1)],
                any_slot(), $urandom_range(0, 49) == 0);
      end else if (pick < 73) begin
        add_req(KIND_MARK_DIRTY, $urandom(), any_slot(), 0);
      end else if (pick < 80) begin
        add_req(KIND_FLUSH_SLOT, $urandom(), any_slot(), 0);
      end else if (pick < 85) begin
        add_req(KIND_FLUSH_ALL, $urandom(), any_slot(), 0);
      end else if (pick < 88) begin
        add_req(KIND_INVALIDATE, $urandom(), any_slot(), 0);
      end else if (pick < 91) begin
        add_req(bad_kind(), $urandom(), any_slot(), 0);
      end else begin
        // fill the cache, dirty most slots, then flush or invalidate in one go
        for (int i = 0; i < SLOTS + 2; i++)
          add_req(KIND_LOOKUP, cluster_pool[$urandom_range(0, POOL_SIZE - 1)],
                  any_slot(), 0);
        for (int i = 0; i < SLOTS; i++)
          if ($urandom_range(0, 4) != 0) add_req(KIND_MARK_DIRTY, $urandom(), i, 0);
        add_req($urandom_range(0, 1) ? KIND_FLUSH_ALL : KIND_INVALIDATE,
                $urandom(), any_slot(), 0);
      end
    end
    n_total = pending_reqs.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // n_sent and the expected queue move together in the driver
    while (!timed_out && !(n_sent == n_total && expected_results.size() == 0))
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (timed_out) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
    end else begin
      if (expected_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      $display("sent %0d requests (lookups, dirty marks, flushes, invalidates, bad kinds)",
               n_sent);
      $display("checked %0d results: %0d hits, %0d writebacks", n_results, n_hits,
               n_writebacks);
      if (n_errors == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule
